// ===== design/stt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Token kinds, scanner modes, character codes and the status word of the
// result queue.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam logic [3:0] KIND_INT   = 4'd11;
    localparam logic [3:0] KIND_IDENT = 4'd12;
    localparam logic [3:0] KIND_END   = 4'd13;
    localparam logic [3:0] KIND_ERROR = 4'd14;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_INT   = 2'd1;
    localparam logic [1:0] MODE_IDENT = 2'd2;
    localparam logic [1:0] MODE_ERROR = 2'd3;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;

    localparam logic [30:0] INT_MAX_VALUE = 31'h7FFF_FFFF;
    localparam logic [15:0] LENGTH_MAX    = 16'hFFFF;

    localparam int RES_FIFO_DEPTH = 4;

    typedef struct packed {
        logic empty;
        logic room2;
    } t_fifo_stat;

    // Returns a hit flag on top of the punctuator's token kind.
    function automatic logic [4:0] punct_code(input logic [7:0] c);
        logic [4:0] code;
        begin
            case (c)
                CH_PLUS:   code = {1'b1, 4'd0};
                CH_MINUS:  code = {1'b1, 4'd1};
                CH_EQUAL:  code = {1'b1, 4'd2};
                CH_STAR:   code = {1'b1, 4'd3};
                CH_COMMA:  code = {1'b1, 4'd4};
                CH_SLASH:  code = {1'b1, 4'd5};
                CH_SEMI:   code = {1'b1, 4'd6};
                CH_LPAREN: code = {1'b1, 4'd7};
                CH_RPAREN: code = {1'b1, 4'd8};
                CH_LBRACE: code = {1'b1, 4'd9};
                CH_RBRACE: code = {1'b1, 4'd10};
                default:   code = 5'd0;
            endcase
            return code;
        end
    endfunction

endpackage

// ===== design/stt_res_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_res_fifo: result queue of the tokenizer
// Takes up to two words per cycle in order and gives one word per cycle to
// the output channel. Reports whether two more words fit.
// ----------------------------------------------------------------------------
module stt_res_fifo #(
    parameter int WIDTH = 108
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_a,
    input  logic [WIDTH-1:0]    i_data_a,
    input  logic                i_push_b,
    input  logic [WIDTH-1:0]    i_data_b,
    input  logic                i_pop,
    output logic [WIDTH-1:0]    o_head,
    output stt_pkg::t_fifo_stat o_stat
);
    import stt_pkg::*;

    localparam int DEPTH    = RES_FIFO_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic [PTR_BITS-1:0] wr_ptr_b;

    assign wr_ptr_b = r_wr_ptr + 1'b1;
    assign o_head = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.room2 = (r_count <= CNT_BITS'(DEPTH - 2));

    always_comb begin
        n_count = r_count + CNT_BITS'(i_push_a) + CNT_BITS'(i_push_b) - CNT_BITS'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push_a && i_push_b) begin
                r_wr_ptr <= r_wr_ptr + PTR_BITS'(2);
            end else if (i_push_a) begin
                r_wr_ptr <= wr_ptr_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wr_ptr] <= i_data_a;
        end
        if (i_push_b) begin
            r_mem[wr_ptr_b] <= i_data_b;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("Result queue count exceeds its depth.");
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_b |-> i_push_a)
        else $error("Second word pushed without the first.");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_a |-> o_stat.room2)
        else $error("Words pushed into a queue without room for two.");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("Word popped from an empty queue.");
`endif

endmodule

// ===== design/source_text_tokenizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_core: streaming lexer for a small C-like language
// Source bytes come in on the input channel, one word per byte, and a word
// with i_end_marker set closes the stream. Tokens leave on the output
// channel, one word per token, with o_last_of_run set on the last token that
// an input word causes.
// A byte is taken into an input register, classified against the scanner
// state once the result queue has room for two words, and its tokens are
// written to a four-word result queue, from which the output channel reads.
// One byte is accepted every cycle while o_stall is low; a byte that ends
// a pending number or identifier and is a punctuator or invalid character
// gives two words; the output drains one word per cycle while i_stall is low.
// When the receiver stalls, the queue fills and i_valid words are held off by
// o_stall once fewer than two queue slots are free; no token is lost.
// Reset clears the scanner, the position counters and the queue. After the
// end token all scanner state returns to its reset values for the next stream.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core #(
    parameter int OFFSET_BITS   = 24,
    parameter int POSITION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_text_byte,
    input  logic                     i_end_marker,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [3:0]               o_token_kind,
    output logic [30:0]              o_int_value,
    output logic                     o_value_overflow,
    output logic [OFFSET_BITS-1:0]   o_start_offset,
    output logic [15:0]              o_text_length,
    output logic [POSITION_BITS-1:0] o_start_line,
    output logic [POSITION_BITS-1:0] o_start_column,
    output logic                     o_last_of_run
);
    import stt_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int PB = POSITION_BITS;
    localparam int RES_BITS = 4 + 31 + 1 + OB + 16 + PB + PB + 1;

    logic          r_in_valid;
    logic [7:0]    r_byte;
    logic          r_end;

    logic [1:0]    r_mode,      n_mode;
    logic [30:0]   r_acc,       n_acc;
    logic          r_ovf,       n_ovf;
    logic [OB-1:0] r_pos,       n_pos;
    logic [PB-1:0] r_line,      n_line;
    logic [PB-1:0] r_col,       n_col;
    logic [OB-1:0] r_pend_off,  n_pend_off;
    logic [PB-1:0] r_pend_line, n_pend_line;
    logic [PB-1:0] r_pend_col,  n_pend_col;
    logic [15:0]   r_pend_len,  n_pend_len;

    t_fifo_stat          fifo_stat;
    logic                fire;
    logic                pop;
    logic                is_digit;
    logic                is_alpha;
    logic                is_ident;
    logic                is_space;
    logic [4:0]          pcode;
    logic                pend;
    logic [34:0]         prod;
    logic                v0;
    logic                v1;
    logic [3:0]          kind0;
    logic [30:0]         val0;
    logic                ovf0;
    logic [3:0]          kind1;
    logic [15:0]         len1;
    logic [RES_BITS-1:0] res0;
    logic [RES_BITS-1:0] res1;
    logic                push_a;
    logic                push_b;
    logic [RES_BITS-1:0] data_a;
    logic [RES_BITS-1:0] data_b;
    logic [RES_BITS-1:0] head;

    assign o_stall = r_in_valid && !fifo_stat.room2;
    assign fire    = r_in_valid && fifo_stat.room2;
    assign o_valid = !fifo_stat.empty;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte <= i_text_byte;
            r_end  <= i_end_marker;
        end
    end

    assign is_digit = (r_byte >= CH_ZERO) && (r_byte <= CH_NINE);
    assign is_alpha = ((r_byte >= CH_LOW_A) && (r_byte <= CH_LOW_Z)) ||
                      ((r_byte >= CH_UP_A) && (r_byte <= CH_UP_Z));
    assign is_ident = is_alpha || is_digit || (r_byte == CH_UNDER);
    assign is_space = (r_byte == CH_SPACE) || ((r_byte >= CH_TAB) && (r_byte <= CH_CR));
    assign pcode    = punct_code(r_byte);
    assign pend     = (r_mode == MODE_INT) || (r_mode == MODE_IDENT);
    assign prod     = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {31'b0, r_byte[3:0]};

    always_comb begin
        n_mode      = r_mode;
        n_acc       = r_acc;
        n_ovf       = r_ovf;
        n_pos       = r_pos;
        n_line      = r_line;
        n_col       = r_col;
        n_pend_off  = r_pend_off;
        n_pend_line = r_pend_line;
        n_pend_col  = r_pend_col;
        n_pend_len  = r_pend_len;
        v0          = 1'b0;
        v1          = 1'b0;
        kind1       = KIND_END;
        len1        = 16'd0;
        if (fire) begin
            if (r_end) begin
                v0          = pend;
                v1          = 1'b1;
                n_mode      = MODE_IDLE;
                n_acc       = '0;
                n_ovf       = 1'b0;
                n_pos       = '0;
                n_line      = '0;
                n_col       = '0;
                n_pend_off  = '0;
                n_pend_line = '0;
                n_pend_col  = '0;
                n_pend_len  = '0;
            end else if (r_mode != MODE_ERROR) begin
                n_pos = (&r_pos) ? r_pos : r_pos + 1'b1;
                if (r_byte == CH_LF) begin
                    n_line = (&r_line) ? r_line : r_line + 1'b1;
                    n_col  = '0;
                end else begin
                    n_col = (&r_col) ? r_col : r_col + 1'b1;
                end
                if ((r_mode == MODE_INT) && is_digit) begin
                    if (prod > {4'b0, INT_MAX_VALUE}) begin
                        n_acc = INT_MAX_VALUE;
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = prod[30:0];
                    end
                    n_pend_len = (r_pend_len == LENGTH_MAX) ? r_pend_len : r_pend_len + 1'b1;
                end else if ((r_mode == MODE_IDENT) && is_ident) begin
                    n_pend_len = (r_pend_len == LENGTH_MAX) ? r_pend_len : r_pend_len + 1'b1;
                end else begin
                    v0     = pend;
                    n_mode = MODE_IDLE;
                    if (is_space) begin
                        n_mode = MODE_IDLE;
                    end else if (pcode[4]) begin
                        v1    = 1'b1;
                        kind1 = pcode[3:0];
                        len1  = 16'd1;
                    end else if (is_digit || is_alpha || (r_byte == CH_UNDER)) begin
                        n_mode      = is_digit ? MODE_INT : MODE_IDENT;
                        n_pend_off  = r_pos;
                        n_pend_line = r_line;
                        n_pend_col  = r_col;
                        n_pend_len  = 16'd1;
                        if (is_digit) begin
                            n_acc = {27'b0, r_byte[3:0]};
                            n_ovf = 1'b0;
                        end
                    end else begin
                        v1     = 1'b1;
                        kind1  = KIND_ERROR;
                        len1   = 16'd1;
                        n_mode = MODE_ERROR;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_pos       <= '0;
            r_line      <= '0;
            r_col       <= '0;
            r_pend_off  <= '0;
            r_pend_line <= '0;
            r_pend_col  <= '0;
            r_pend_len  <= '0;
        end else begin
            r_mode      <= n_mode;
            r_acc       <= n_acc;
            r_ovf       <= n_ovf;
            r_pos       <= n_pos;
            r_line      <= n_line;
            r_col       <= n_col;
            r_pend_off  <= n_pend_off;
            r_pend_line <= n_pend_line;
            r_pend_col  <= n_pend_col;
            r_pend_len  <= n_pend_len;
        end
    end

    assign kind0 = (r_mode == MODE_INT) ? KIND_INT : KIND_IDENT;
    assign val0  = (r_mode == MODE_INT) ? r_acc : 31'd0;
    assign ovf0  = (r_mode == MODE_INT) ? r_ovf : 1'b0;

    assign res0 = {kind0, val0, ovf0, r_pend_off, r_pend_len, r_pend_line, r_pend_col, !v1};
    assign res1 = {kind1, 31'd0, 1'b0, r_pos, len1, r_line, r_col, 1'b1};

    assign push_a = v0 || v1;
    assign push_b = v0 && v1;
    assign data_a = v0 ? res0 : res1;
    assign data_b = res1;

    stt_res_fifo #(
        .WIDTH (RES_BITS)
    ) u_res_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (push_a),
        .i_data_a (data_a),
        .i_push_b (push_b),
        .i_data_b (data_b),
        .i_pop    (pop),
        .o_head   (head),
        .o_stat   (fifo_stat)
    );

    assign {o_token_kind, o_int_value, o_value_overflow, o_start_offset, o_text_length,
            o_start_line, o_start_column, o_last_of_run} = head;

`ifndef SYNTH
    a_sink_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_end && (r_mode == MODE_ERROR)) |-> !push_a)
        else $error("A byte after an error produced a token.");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_end) |=> ((r_mode == MODE_IDLE) && (r_pos == '0) && (r_line == '0)))
        else $error("Scanner state not cleared after the end marker.");
    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_mode == MODE_INT) && r_ovf) |-> (r_acc == INT_MAX_VALUE))
        else $error("Overflowed number is not saturated.");
    a_end_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_end) |-> push_a)
        else $error("End marker gave no token.");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for source_text_tokenizer_core
// Feeds directed and random source text through the input channel and checks
// every token word, in order, against a lexer model kept inside the bench.
// Both channels idle at random. The receiver also holds off long enough to
// back the block up into its input. Long numbers, names and newline runs
// exercise value saturation and wide lengths, columns and lines.
// ----------------------------------------------------------------------------
module tb;
    import stt_pkg::*;

    localparam int OFF_W       = 24;
    localparam int POS_W       = 16;
    localparam int NUM_PUNCT   = 11;
    localparam int HOLD_CYCLES = 150;
    localparam int LONG_RUN    = 40;
    localparam int LINE_RUN    = 12;
    localparam int RANDOM_WORDS = 1600;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [OFF_W-1:0] OFF_MAX = '1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [7:0] PUNCT_CHARS [NUM_PUNCT] = '{
        CH_PLUS, CH_MINUS, CH_EQUAL, CH_STAR, CH_COMMA, CH_SLASH,
        CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE
    };
    localparam logic [7:0] BLANK_CHARS [6] = '{
        CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR
    };

    typedef struct packed {
        logic [3:0]       kind;
        logic [30:0]      value;
        logic             ovf;
        logic [OFF_W-1:0] off;
        logic [15:0]      len;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] col;
        logic             last;
    } tok_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [7:0] i_text_byte = 8'h00;
    logic i_end_marker = 1'b0;
    logic i_stall = 1'b0;

    logic o_stall;
    logic o_valid;
    logic [3:0] o_token_kind;
    logic [30:0] o_int_value;
    logic o_value_overflow;
    logic [OFF_W-1:0] o_start_offset;
    logic [15:0] o_text_length;
    logic [POS_W-1:0] o_start_line;
    logic [POS_W-1:0] o_start_column;
    logic o_last_of_run;

    tok_t expected_tokens[$];

    logic [1:0]       lx_mode;
    logic [30:0]      acc;
    logic             acc_ovf;
    logic [OFF_W-1:0] pos_off;
    logic [POS_W-1:0] pos_line;
    logic [POS_W-1:0] pos_col;
    logic [OFF_W-1:0] tok_off;
    logic [POS_W-1:0] tok_line;
    logic [POS_W-1:0] tok_col;
    logic [15:0]      tok_len;

    int step_tokens;
    int words_sent = 0;
    int words_scanned = 0;
    int streams_closed = 0;
    int tokens_checked = 0;
    int mismatch_count = 0;

    bit tx_gaps_on = 1'b1;
    bit rx_stall_on = 1'b1;
    bit hold_req = 1'b0;
    bit hold_armed = 1'b0;
    int hold_left = 0;
    int stall_left = 0;

    source_text_tokenizer_core #(
        .OFFSET_BITS(OFF_W),
        .POSITION_BITS(POS_W)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_text_byte(i_text_byte),
        .i_end_marker(i_end_marker),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_token_kind(o_token_kind),
        .o_int_value(o_int_value),
        .o_value_overflow(o_value_overflow),
        .o_start_offset(o_start_offset),
        .o_text_length(o_text_length),
        .o_start_line(o_start_line),
        .o_start_column(o_start_column),
        .o_last_of_run(o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic bit is_alpha(input logic [7:0] b);
        return (b >= CH_LOW_A && b <= CH_LOW_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
    endfunction

    function automatic bit is_word_char(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == CH_UNDER;
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic int punct_kind(input logic [7:0] b);
        int k;
        for (k = 0; k < NUM_PUNCT; k++) begin
            if (PUNCT_CHARS[k] == b) return k;
        end
        return -1;
    endfunction

    function automatic logic [7:0] rand_word_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26) return 8'(CH_LOW_A + r);
        if (r < 52) return 8'(CH_UP_A + r - 26);
        if (r == 52) return CH_UNDER;
        return 8'(CH_ZERO + r - 53);
    endfunction

    function automatic string tok_text(input tok_t t);
        return $sformatf("kind=%0d value=%0d ovf=%0b off=%0d len=%0d line=%0d col=%0d last=%0b",
                         t.kind, t.value, t.ovf, t.off, t.len, t.line, t.col, t.last);
    endfunction

    task automatic reset_lexer();
        lx_mode = MODE_IDLE;
        acc = '0;
        acc_ovf = 1'b0;
        pos_off = '0;
        pos_line = '0;
        pos_col = '0;
        tok_off = '0;
        tok_line = '0;
        tok_col = '0;
        tok_len = '0;
    endtask

    task automatic emit_tok(input logic [3:0] k, input logic [30:0] v, input logic f,
                            input logic [OFF_W-1:0] o, input logic [15:0] n,
                            input logic [POS_W-1:0] l, input logic [POS_W-1:0] c);
        tok_t t;
        t = '{k, v, f, o, n, l, c, 1'b0};
        expected_tokens.push_back(t);
        step_tokens++;
    endtask

    task automatic advance_pos(input logic [7:0] b);
        if (pos_off != OFF_MAX) pos_off = pos_off + 1'b1;
        if (b == CH_LF) begin
            if (pos_line != POS_MAX) pos_line = pos_line + 1'b1;
            pos_col = '0;
        end else if (pos_col != POS_MAX) begin
            pos_col = pos_col + 1'b1;
        end
    endtask

    task automatic flush_pending();
        if (lx_mode == MODE_INT) begin
            emit_tok(KIND_INT, acc, acc_ovf, tok_off, tok_len, tok_line, tok_col);
        end else if (lx_mode == MODE_IDENT) begin
            emit_tok(KIND_IDENT, '0, 1'b0, tok_off, tok_len, tok_line, tok_col);
        end
        lx_mode = MODE_IDLE;
    endtask

    task automatic open_token(input logic [1:0] mode);
        lx_mode = mode;
        tok_off = pos_off;
        tok_line = pos_line;
        tok_col = pos_col;
        tok_len = 16'd1;
    endtask

    // Works out the tokens that one accepted word causes.
    task automatic lex_word(input logic [7:0] b, input logic e);
        logic [63:0] grown;
        int k;
        tok_t t;
        step_tokens = 0;
        if (e || lx_mode != MODE_ERROR) words_scanned++;
        if (e) begin
            flush_pending();
            emit_tok(KIND_END, '0, 1'b0, pos_off, '0, pos_line, pos_col);
            reset_lexer();
            streams_closed++;
        end else if (lx_mode == MODE_ERROR) begin
            step_tokens = 0;
        end else if (lx_mode == MODE_INT && is_digit(b)) begin
            grown = {33'd0, acc} * 64'd10 + 64'(b - CH_ZERO);
            if (grown > 64'(INT_MAX_VALUE)) begin
                acc = INT_MAX_VALUE;
                acc_ovf = 1'b1;
            end else begin
                acc = grown[30:0];
            end
            if (tok_len != LENGTH_MAX) tok_len = tok_len + 1'b1;
            advance_pos(b);
        end else if (lx_mode == MODE_IDENT && is_word_char(b)) begin
            if (tok_len != LENGTH_MAX) tok_len = tok_len + 1'b1;
            advance_pos(b);
        end else begin
            flush_pending();
            k = punct_kind(b);
            if (is_blank(b)) begin
                advance_pos(b);
            end else if (k >= 0) begin
                emit_tok(4'(k), '0, 1'b0, pos_off, 16'd1, pos_line, pos_col);
                advance_pos(b);
            end else if (is_digit(b)) begin
                open_token(MODE_INT);
                acc = 31'(b - CH_ZERO);
                acc_ovf = 1'b0;
                advance_pos(b);
            end else if (is_alpha(b) || b == CH_UNDER) begin
                open_token(MODE_IDENT);
                advance_pos(b);
            end else begin
                emit_tok(KIND_ERROR, '0, 1'b0, pos_off, 16'd1, pos_line, pos_col);
                lx_mode = MODE_ERROR;
                advance_pos(b);
            end
        end
        if (step_tokens > 0) begin
            t = expected_tokens.pop_back();
            t.last = 1'b1;
            expected_tokens.push_back(t);
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic e);
        int gap;
        i_valid <= 1'b1;
        i_text_byte <= b;
        i_end_marker <= e;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
        lex_word(b, e);
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) send_word(s[k], 1'b0);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_tokens.size() != 0);
    endtask

    task automatic test_punctuators_and_blanks();
        send_text("+ -\t=\n*\v,\f/\015;(){}");
        send_word(8'h00, 1'b1);
    endtask

    task automatic test_numbers_and_names();
        send_text("2147483647 2147483648_Zz9 12ab");
        send_word(CH_SPACE, 1'b1);
    endtask

    task automatic test_error_recovery();
        send_text("a\200q\n+");
        send_word(8'hFF, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(CH_ZERO, 1'b1);
        send_word(8'h00, 1'b1);
    endtask

    task automatic test_output_holdoff();
        int k;
        wait_drain();
        hold_req <= 1'b1;
        tx_gaps_on = 1'b0;
        for (k = 0; k < 40; k++) send_word(PUNCT_CHARS[k % NUM_PUNCT], 1'b0);
        send_text("7x");
        send_word(CH_LF, 1'b1);
        wait_drain();
        hold_req <= 1'b0;
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_long_runs();
        int k;
        tx_gaps_on = 1'b0;
        for (k = 0; k < LONG_RUN; k++) send_word(8'(CH_ZERO + $urandom_range(1, 9)), 1'b0);
        send_text("+");
        send_word(CH_SPACE, 1'b1);
        send_word(rand_word_char(1'b1), 1'b0);
        for (k = 1; k < LONG_RUN; k++) send_word(rand_word_char(1'b0), 1'b0);
        for (k = 0; k < LINE_RUN; k++) send_word(CH_LF, 1'b0);
        send_text("_");
        send_word(CH_LF, 1'b1);
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_streams();
        int goal;
        int toks;
        int sel;
        int n;
        int k;
        int j;
        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal) begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_stall_on <= ($urandom_range(0, 3) != 0);
            toks = $urandom_range(2, 30);
            for (k = 0; k < toks; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 35) begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
                    send_word(rand_word_char(1'b1), 1'b0);
                    for (j = 1; j < n; j++) send_word(rand_word_char(1'b0), 1'b0);
                end else if (sel < 60) begin
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 5);
                    for (j = 0; j < n; j++) send_word(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
                end else if (sel < 85) begin
                    send_word(PUNCT_CHARS[$urandom_range(0, NUM_PUNCT - 1)], 1'b0);
                end else if (sel < 98) begin
                    n = $urandom_range(1, 3);
                    for (j = 0; j < n; j++) send_word(BLANK_CHARS[$urandom_range(0, 5)], 1'b0);
                end else begin
                    send_word(8'($urandom_range(0, 255)), 1'b0);
                end
                if ($urandom_range(0, 1) == 0) begin
                    send_word(BLANK_CHARS[$urandom_range(0, 5)], 1'b0);
                end
            end
            send_word(8'($urandom_range(0, 255)), 1'b1);
            if ($urandom_range(0, 7) == 0) wait_drain();
        end
        rx_stall_on <= 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (!hold_req) begin
            hold_armed = 1'b0;
        end else if (!hold_armed) begin
            hold_armed = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (rx_stall_on && $urandom_range(0, 2) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        tok_t seen;
        tok_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            seen = '{o_token_kind, o_int_value, o_value_overflow, o_start_offset,
                     o_text_length, o_start_line, o_start_column, o_last_of_run};
            tokens_checked++;
            if (expected_tokens.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected token: %s", tok_text(seen));
            end else begin
                want = expected_tokens.pop_front();
                if (seen !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("token mismatch at %0t", $realtime);
                        $display("  expected %s", tok_text(want));
                        $display("  actual   %s", tok_text(seen));
                    end
                end
            end
        end
    end

    initial begin
        reset_lexer();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_punctuators_and_blanks();
        test_numbers_and_names();
        test_error_recovery();
        test_output_holdoff();
        test_long_runs();
        test_random_streams();
        wait_drain();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d source words (%0d scanned) in %0d streams, checked %0d tokens,",
                 words_sent, words_scanned, streams_closed, tokens_checked);
        $display("with error recovery, output hold-off and long tokens; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0 && expected_tokens.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d tokens outstanding.", expected_tokens.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
